// File: rtl/core/tcf_pkg.sv
// shared types and constants for the tilt complementary filter
`default_nettype none
package tcf_pkg;
	localparam int ACC_W = 12;
	localparam int RATE_W = 16;
	localparam int ANG_W = 32;
	localparam int GAIN_W = 24;
	localparam int KEEP_W = 17;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] REG_GYRO_GAIN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEEP_WEIGHT = 1'd1;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd292836;
	localparam logic [KEEP_W-1:0] KEEP_RESET = 17'd52429;
	localparam logic [KEEP_W-1:0] KEEP_ONE = 17'd65536;
	localparam int CD_W = 48;
	localparam int Z_W = 34;
	localparam int MSQ_W = 24;
	localparam int ROOT_W = 28;
	localparam int NLANES = 3;

	typedef struct packed {
		logic start;
		logic mode;
	} lane_ctl_t;

	function automatic logic signed [Z_W-1:0] atan_entry(input logic [4:0] i);
		logic signed [Z_W-1:0] r;
		case (i)
			5'd0: r = 34'sd843314856;
			5'd1: r = 34'sd497837829;
			5'd2: r = 34'sd263043836;
			5'd3: r = 34'sd133525158;
			5'd4: r = 34'sd67021686;
			5'd5: r = 34'sd33543515;
			5'd6: r = 34'sd16775850;
			5'd7: r = 34'sd8388437;
			5'd8: r = 34'sd4194282;
			5'd9: r = 34'sd2097149;
			default: r = (i <= 5'd30) ? (34'sd1 <<< (5'd30 - i)) : 34'sd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [ANG_W-1:0] sat32(input logic signed [63:0] v);
		logic signed [ANG_W-1:0] r;
		if (v > 64'sh7fffffff) r = 32'sh7fffffff;
		else if (v < -64'sh80000000) r = 32'sh80000000;
		else r = v[ANG_W-1:0];
		return r;
	endfunction
endpackage
`default_nettype wire

// File: rtl/core/tcf_lane.sv
// one lane: gyro step or sqrt, cordic atan and blend for one angle
`default_nettype none
module tcf_lane import tcf_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = 28,
	parameter int CORDIC_STEPS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire lane_ctl_t ctl,
	input wire logic signed [ACC_W:0] axis,
	input wire logic signed [ACC_W:0] other_b,
	input wire logic signed [ACC_W:0] other_c,
	input wire logic signed [RATE_W-1:0] rate,
	input wire logic [GAIN_W-1:0] gain,
	input wire logic [KEEP_W-1:0] keep,
	input wire logic signed [ANG_W-1:0] old,
	output logic done,
	output logic signed [ANG_W-1:0] angle
);
	localparam logic [3:0] S_IDLE = 4'd0, S_GMUL = 4'd1, S_SQ = 4'd2, S_SQRT = 4'd3,
		S_CORD = 4'd4, S_RND = 4'd5, S_M1 = 4'd6, S_M2 = 4'd7, S_FIN = 4'd8;
	localparam int GSH = 36 - ANGLE_FRAC_BITS;
	localparam int ZSH = 30 - ANGLE_FRAC_BITS;
	localparam int NUM_W = MSQ_W + 32;

	logic [3:0] state_q;
	logic [4:0] cnt_q;
	logic signed [ACC_W:0] a_q, b_q, c_q;
	logic [NUM_W-1:0] rem_q;
	logic [ROOT_W+3:0] root_q;
	logic [NUM_W-1:0] num_q;
	logic signed [CD_W-1:0] x_q, y_q;
	logic signed [Z_W-1:0] z_q;
	logic signed [63:0] acc_q;
	logic signed [ANG_W+1:0] tgt_q;
	logic nz_q;

	logic [NUM_W-1:0] trial;
	logic signed [CD_W-1:0] dx, dy;
	logic signed [63:0] rnd;
	logic signed [KEEP_W:0] keep_s;

	always_comb begin
		trial = {root_q, 2'b00} | NUM_W'(1);
		dx = y_q >>> (cnt_q - 5'd1);
		dy = x_q >>> (cnt_q - 5'd1);
		keep_s = (keep > KEEP_ONE) ? $signed({1'b0, KEEP_ONE}) : $signed({1'b0, keep});
		rnd = acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: if (ctl.start) begin
					a_q <= axis; b_q <= other_b; c_q <= other_c;
					acc_q <= 64'(rate) * $signed({1'b0, gain});
					state_q <= ctl.mode ? S_SQ : S_GMUL;
				end
				S_GMUL: begin
					angle <= sat32(64'(old) - ((acc_q + (64'sd1 <<< (GSH - 1))) >>> GSH));
					done <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SQ: begin
					num_q <= NUM_W'(32'(b_q * b_q) + 32'(c_q * c_q)) << 32;
					nz_q <= (b_q != '0) || (c_q != '0);
					rem_q <= '0; root_q <= '0; cnt_q <= 5'd0;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					if (NUM_W'({rem_q, num_q[NUM_W-1:NUM_W-2]}) >= trial) begin
						rem_q <= NUM_W'({rem_q, num_q[NUM_W-1:NUM_W-2]}) - trial;
						root_q <= {root_q[ROOT_W+2:0], 1'b1};
					end else begin
						rem_q <= NUM_W'({rem_q, num_q[NUM_W-1:NUM_W-2]});
						root_q <= {root_q[ROOT_W+2:0], 1'b0};
					end
					num_q <= num_q << 2;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(ROOT_W - 1)) begin
						cnt_q <= 5'd0;
						state_q <= S_CORD;
					end
				end
				S_CORD: begin
					if (cnt_q == 5'd0) begin
						x_q <= CD_W'(root_q);
						y_q <= CD_W'(a_q) <<< 16;
						z_q <= '0;
						cnt_q <= 5'd1;
						if (!nz_q) state_q <= S_M1;
					end else begin
						if (y_q >= 0) begin
							x_q <= x_q + dx; y_q <= y_q - dy;
							z_q <= z_q + atan_entry(cnt_q - 5'd1);
						end else begin
							x_q <= x_q - dx; y_q <= y_q + dy;
							z_q <= z_q - atan_entry(cnt_q - 5'd1);
						end
						cnt_q <= cnt_q + 5'd1;
						if (cnt_q == 5'(CORDIC_STEPS)) state_q <= S_RND;
					end
				end
				S_RND: begin
					if (ZSH == 0) tgt_q <= z_q;
					else tgt_q <= (z_q + (34'sd1 <<< (ZSH == 0 ? 0 : ZSH - 1))) >>> ZSH;
					state_q <= S_M1;
				end
				S_M1: begin
					acc_q <= 64'(old) * 64'(keep_s);
					state_q <= nz_q ? S_M2 : S_FIN;
				end
				S_M2: begin
					acc_q <= acc_q + 64'(tgt_q) * 64'(18'sd65536 - keep_s);
					state_q <= S_FIN;
				end
				S_FIN: begin
					angle <= sat32((rnd + 64'sd32768) >>> 16);
					done <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// cordic index never runs past its table
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CORD |-> cnt_q <= 5'(CORDIC_STEPS)) else $error("cordic count");
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == S_GMUL || $past(state_q) == S_FIN) else $error("done");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SQRT |-> cnt_q <= 5'(ROOT_W - 1)) else $error("sqrt count");
endmodule
`default_nettype wire

// File: rtl/core/tilt_complementary_filter.sv
// top level: config registers, three parallel lanes, result merge and output register
// An accel transaction runs from acceptance to out_valid through a squaring step, 28
// root steps, a load step, CORDIC_STEPS rotations, rounding, two multiply steps and
// the final round in each of three parallel lanes, then the merge; a lane whose other
// two axes are both zero skips the rotations and the target term. The result is held
// in the angle registers until taken and a new transaction is accepted the cycle after
// that. Angles are radians in Q(ANGLE_FRAC_BITS), saturated.
`default_nettype none
module tilt_complementary_filter import tcf_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = 28,
	parameter int CORDIC_STEPS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic mode,
	input wire logic signed [ACC_W-1:0] accel_x_count,
	input wire logic signed [ACC_W-1:0] accel_y_count,
	input wire logic signed [ACC_W-1:0] accel_z_count,
	input wire logic signed [RATE_W-1:0] rate_x_count,
	input wire logic signed [RATE_W-1:0] rate_y_count,
	output logic out_valid,
	input wire logic out_ready,
	output logic signed [ANG_W-1:0] angle_x,
	output logic signed [ANG_W-1:0] angle_y,
	output logic signed [ANG_W-1:0] angle_z
);
	logic [GAIN_W-1:0] gain_q;
	logic [KEEP_W-1:0] keep_q;
	logic busy_q;
	logic signed [ANG_W-1:0] tilt_q [NLANES];
	logic signed [ANG_W-1:0] res [NLANES];
	logic [NLANES-1:0] dn;
	logic [NLANES-1:0] got_q;
	lane_ctl_t ctl;
	logic signed [ACC_W:0] ax, ay, az;
	logic fire;

	assign in_ready = !busy_q && !out_valid;
	assign fire = in_valid && in_ready;
	assign ctl = '{start: fire, mode: mode};
	assign ax = -(13'(accel_x_count));
	assign ay = 13'(accel_y_count);
	assign az = -(13'(accel_z_count));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
			keep_q <= KEEP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GYRO_GAIN: gain_q <= cfg_data;
				REG_KEEP_WEIGHT: keep_q <= cfg_data[KEEP_W-1:0];
				default: ;
			endcase
		end
	end

	tcf_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_lx (
		.clk, .arst_n, .ctl, .axis(ax), .other_b(ay), .other_c(az), .rate(rate_y_count),
		.gain(gain_q), .keep(keep_q), .old(tilt_q[0]), .done(dn[0]), .angle(res[0]));
	tcf_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_ly (
		.clk, .arst_n, .ctl, .axis(ay), .other_b(az), .other_c(ax), .rate(rate_x_count),
		.gain(gain_q), .keep(keep_q), .old(tilt_q[1]), .done(dn[1]), .angle(res[1]));
	tcf_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_lz (
		.clk, .arst_n, .ctl, .axis(az), .other_b(ax), .other_c(ay), .rate(rate_y_count),
		.gain(gain_q), .keep(keep_q), .old(tilt_q[2]), .done(dn[2]), .angle(res[2]));

	// merge: a lane with zero magnitude finishes early, so collect each done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			out_valid <= 1'b0;
			got_q <= '0;
			for (int i = 0; i < NLANES; i++) tilt_q[i] <= '0;
		end else begin
			if (fire) busy_q <= 1'b1;
			if (out_valid && out_ready) out_valid <= 1'b0;
			for (int i = 0; i < NLANES; i++)
				if (dn[i]) tilt_q[i] <= res[i];
			if (busy_q && ((got_q | dn) == '1)) begin
				got_q <= '0;
				busy_q <= 1'b0;
				out_valid <= 1'b1;
			end else begin
				got_q <= got_q | dn;
			end
		end
	end

	assign angle_x = tilt_q[0];
	assign angle_y = tilt_q[1];
	assign angle_z = tilt_q[2];

	assert property (@(posedge clk) disable iff (!arst_n)
		!(busy_q && out_valid)) else $error("busy with result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(busy_q)) else $error("result without transaction");
	assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> dn == '0) else $error("lane done while idle");
endmodule
`default_nettype wire
